// File: rtl/core/cfa_pkg.sv
// Shared types, constants and helpers of the circular first-free slot allocator.
package cfa_pkg;

  // Payload field widths
  localparam int CFA_SLOT_W     = 10;
  localparam int CFA_COUNT_W    = 11;
  localparam int CFA_IN_DATA_W  = 16;
  localparam int CFA_OUT_DATA_W = 16;

  // Occupancy bitmap word
  localparam int CFA_WORD_W  = 32;
  localparam int CFA_WORD_LG = 5;

  // Defaults
  localparam int CFA_MAX_SLOTS_DEF = 1024;
  localparam int CFA_COUNT_RST     = 1024;

  // Request kinds carried on in_tuser
  localparam logic CFA_MODE_ALLOC   = 1'b0;
  localparam logic CFA_MODE_RELEASE = 1'b1;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_FIRST,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_WORD_CHK,
    ST_GRANT,
    ST_FULL,
    ST_REL
  } cfa_state_t;

  // Index of the lowest set bit of a bitmap word (0 when none set)
  function automatic logic [CFA_WORD_LG-1:0] cfa_lowest_set(input logic [CFA_WORD_W-1:0] v);
    logic [CFA_WORD_LG-1:0] res;
    res = '0;
    for (int i = CFA_WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        res = CFA_WORD_LG'(i);
      end
    end
    return res;
  endfunction

endpackage

// File: rtl/core/circular_first_free_allocator.sv
// Top level of the circular first-free slot allocator.
//
//  channel | direction | tdata                        | tuser
//  --------+-----------+------------------------------+----------------------------
//  in_     | slave     | [9:0] slot, [15:10] zero     | [0] mode (0 alloc, 1 release)
//  out_    | master    | [9:0] granted_slot, rest 0   | [0] full_res
//  cfg_    | slave     | cfg_data = spot_count        | -
//
// Occupancy sits in a bitmap RAM of 32-bit words (one bit per slot, set = free) plus a
// summary RAM with one bit per bitmap word (set = word has a free slot); both have a
// registered read. An allocate grants from the start word when it holds a free slot,
// else from a word that the start summary word marks free above the start word, else
// from the walk over summary words, each read (SCAN_RD) and then checked (SCAN_CHK).
// Reset and every spot_count write run a rebuild sweep, one bitmap word per cycle,
// with in_tready low.
// A grant waits in place while the output register is still held by a stall.
module circular_first_free_allocator #(
  parameter int MAX_SLOTS = cfa_pkg::CFA_MAX_SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [cfa_pkg::CFA_IN_DATA_W-1:0]   in_tdata,   // [9:0] slot
  input  logic                                in_tuser,   // [0] mode
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [cfa_pkg::CFA_OUT_DATA_W-1:0]  out_tdata,  // [9:0] granted_slot
  output logic                                out_tuser,  // [0] full_res
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cfa_pkg::CFA_COUNT_W-1:0]     cfg_data    // spot_count
);
  import cfa_pkg::*;

  localparam int NW  = (MAX_SLOTS + CFA_WORD_W - 1) / CFA_WORD_W;
  localparam int NWA = (NW > 1) ? $clog2(NW) : 1;
  localparam int NS  = (NW + CFA_WORD_W - 1) / CFA_WORD_W;
  localparam int NSA = (NS > 1) ? $clog2(NS) : 1;
  localparam int IW  = NWA + CFA_WORD_LG;
  localparam int CW  = $clog2(MAX_SLOTS + 1);
  localparam int RST_COUNT = (CFA_COUNT_RST > MAX_SLOTS) ? MAX_SLOTS : CFA_COUNT_RST;
  localparam logic [CFA_WORD_W-1:0] ONES = '1;

  // Mask of bits whose index base + i lies below limit
  function automatic logic [CFA_WORD_W-1:0] fill_mask(input logic [31:0] base,
                                                      input logic [31:0] limit);
    logic [31:0] diff;
    logic [CFA_WORD_W-1:0] m;
    diff = limit - base;
    if (limit <= base) begin
      m = '0;
    end else if (diff >= 32'(CFA_WORD_W)) begin
      m = ONES;
    end else begin
      m = (CFA_WORD_W'(1) << diff[CFA_WORD_LG-1:0]) - CFA_WORD_W'(1);
    end
    return m;
  endfunction

  // Memories
  logic [CFA_WORD_W-1:0] bm_mem [NW];
  logic [CFA_WORD_W-1:0] sm_mem [NS];

  // State and datapath registers
  cfa_state_t            state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [IW-1:0]         start_r, start_nxt;
  logic [NSA-1:0]        scan_r, scan_nxt;
  logic                  wrap_r, wrap_nxt;
  logic [NWA-1:0]        word_r, word_nxt;
  logic [CFA_WORD_LG-1:0] bit_r, bit_nxt;
  logic [NWA-1:0]        ptr_r, ptr_nxt;
  logic [CFA_WORD_W-1:0] bm_rdata_r, sm_rdata_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [CFA_SLOT_W-1:0] out_slot_r;
  logic                  out_full_r;

  // Memory and output controls
  logic                  bm_re, sm_re, bm_we, sm_we;
  logic [NWA-1:0]        bm_raddr, bm_waddr;
  logic [NSA-1:0]        sm_raddr, sm_waddr;
  logic [CFA_WORD_W-1:0] bm_wdata, sm_wdata;
  logic                  out_load, out_load_full;

  // Request decode
  logic [CFA_SLOT_W-1:0] in_slot;
  logic                  in_in_range;
  logic [IW-1:0]         in_start;
  logic [NWA-1:0]        in_word;

  // Search terms
  logic [NWA-1:0]         start_word;
  logic [CFA_WORD_LG-1:0] start_bit;
  logic [NSA-1:0]         start_sa;
  logic [CFA_WORD_LG-1:0] start_wlo;
  logic [CFA_WORD_W-1:0]  first_m, above_m;
  logic                   first_hit, above_hit, scan_hit;
  logic [NWA-1:0]         w_above, w_scan;
  logic [CFA_WORD_W-1:0]  bm_clr, sm_clr, bm_set, sm_set;
  logic                   out_free;
  logic [31:0]            sweep_base, nw_used;

  assign in_slot     = in_tdata[CFA_SLOT_W-1:0];
  assign in_in_range = 32'(in_slot) < 32'(count_r);
  assign in_start    = in_in_range ? IW'(in_slot) : '0;
  assign in_word     = in_start[IW-1:CFA_WORD_LG];

  assign start_word = start_r[IW-1:CFA_WORD_LG];
  assign start_bit  = start_r[CFA_WORD_LG-1:0];
  assign start_sa   = NSA'(start_word >> CFA_WORD_LG);
  assign start_wlo  = CFA_WORD_LG'(start_word);

  // Free slots at or above the start, then free words above the start word
  assign first_m   = bm_rdata_r & (ONES << start_bit);
  assign first_hit = |first_m;
  assign above_m   = sm_rdata_r & ((ONES << start_wlo) << 1);
  assign above_hit = |above_m;
  assign scan_hit  = |sm_rdata_r;
  assign w_above   = NWA'({start_sa, cfa_lowest_set(above_m)});
  assign w_scan    = NWA'({scan_r, cfa_lowest_set(sm_rdata_r)});

  // Read-modify-write data
  assign bm_clr = bm_rdata_r & ~(CFA_WORD_W'(1) << bit_r);
  assign sm_clr = sm_rdata_r & ~(CFA_WORD_W'(1) << CFA_WORD_LG'(word_r));
  assign bm_set = bm_rdata_r | (CFA_WORD_W'(1) << start_bit);
  assign sm_set = sm_rdata_r | (CFA_WORD_W'(1) << start_wlo);

  assign out_free   = !out_valid_r || out_tready;
  assign sweep_base = 32'(ptr_r) << CFA_WORD_LG;
  assign nw_used    = (32'(count_r) + 32'(CFA_WORD_W - 1)) >> CFA_WORD_LG;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_SWEEP:    if (32'(ptr_r) == 32'(NW - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == CFA_MODE_ALLOC) begin
            state_nxt = ST_FIRST;
          end else if (in_in_range) begin
            state_nxt = ST_REL;
          end
        end
      end
      ST_FIRST: begin
        if (first_hit) begin
          state_nxt = ST_GRANT;
        end else if (above_hit) begin
          state_nxt = ST_WORD_CHK;
        end else begin
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD:  state_nxt = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (scan_hit) begin
          state_nxt = ST_WORD_CHK;
        end else if (wrap_r && scan_r == start_sa) begin
          state_nxt = ST_FULL;
        end else begin
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_WORD_CHK: state_nxt = ST_GRANT;
      ST_GRANT:    if (out_free) state_nxt = ST_IDLE;
      ST_FULL:     if (out_free) state_nxt = ST_IDLE;
      ST_REL:      state_nxt = ST_IDLE;
      default:     state_nxt = ST_SWEEP;
    endcase
    // A count write restarts the rebuild
    if (cfg_valid) state_nxt = ST_SWEEP;
  end

  // Outputs: memory ports, handshake, result load
  always_comb begin
    in_tready     = 1'b0;
    bm_re         = 1'b0;
    bm_raddr      = '0;
    sm_re         = 1'b0;
    sm_raddr      = '0;
    bm_we         = 1'b0;
    bm_waddr      = '0;
    bm_wdata      = '0;
    sm_we         = 1'b0;
    sm_waddr      = '0;
    sm_wdata      = '0;
    out_load      = 1'b0;
    out_load_full = 1'b0;
    unique case (state_r)
      ST_SWEEP: begin
        bm_we    = 1'b1;
        bm_waddr = ptr_r;
        bm_wdata = fill_mask(sweep_base, 32'(count_r));
        sm_we    = 32'(ptr_r) < 32'(NS);
        sm_waddr = NSA'(ptr_r);
        sm_wdata = fill_mask(sweep_base, nw_used);
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        bm_re     = in_tvalid;
        bm_raddr  = in_word;
        sm_re     = in_tvalid;
        sm_raddr  = NSA'(in_word >> CFA_WORD_LG);
      end
      ST_FIRST: begin
        if (!first_hit && above_hit) begin
          bm_re    = 1'b1;
          bm_raddr = w_above;
        end
      end
      ST_SCAN_RD: begin
        sm_re    = 1'b1;
        sm_raddr = scan_r;
      end
      ST_SCAN_CHK: begin
        if (scan_hit) begin
          bm_re    = 1'b1;
          bm_raddr = w_scan;
        end
      end
      ST_WORD_CHK: begin
      end
      ST_GRANT: begin
        if (out_free) begin
          bm_we    = 1'b1;
          bm_waddr = word_r;
          bm_wdata = bm_clr;
          // last free slot of the word gone: clear its summary bit
          sm_we    = (bm_clr == '0);
          sm_waddr = NSA'(word_r >> CFA_WORD_LG);
          sm_wdata = sm_clr;
          out_load = 1'b1;
        end
      end
      ST_FULL: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_load_full = 1'b1;
        end
      end
      ST_REL: begin
        bm_we    = 1'b1;
        bm_waddr = start_word;
        bm_wdata = bm_set;
        sm_we    = 1'b1;
        sm_waddr = start_sa;
        sm_wdata = sm_set;
      end
      default: begin
      end
    endcase
  end

  // Datapath next values
  always_comb begin
    count_nxt = count_r;
    start_nxt = start_r;
    scan_nxt  = scan_r;
    wrap_nxt  = wrap_r;
    word_nxt  = word_r;
    bit_nxt   = bit_r;
    ptr_nxt   = ptr_r;
    unique case (state_r)
      ST_SWEEP:  ptr_nxt = ptr_r + 1'b1;
      ST_IDLE:   if (in_tvalid) start_nxt = in_start;
      ST_FIRST: begin
        if (first_hit) begin
          word_nxt = start_word;
          bit_nxt  = cfa_lowest_set(first_m);
        end else if (above_hit) begin
          word_nxt = w_above;
        end else if (32'(start_sa) == 32'(NS - 1)) begin
          scan_nxt = '0;
          wrap_nxt = 1'b1;
        end else begin
          scan_nxt = start_sa + 1'b1;
          wrap_nxt = 1'b0;
        end
      end
      ST_SCAN_CHK: begin
        if (scan_hit) begin
          word_nxt = w_scan;
        end else if (!wrap_r && 32'(scan_r) == 32'(NS - 1)) begin
          scan_nxt = '0;
          wrap_nxt = 1'b1;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      ST_WORD_CHK: bit_nxt = cfa_lowest_set(bm_rdata_r);
      default: begin
      end
    endcase
    // Count write saturates at the slot capacity
    if (cfg_valid) begin
      ptr_nxt = '0;
      if (32'(cfg_data) > 32'(MAX_SLOTS)) begin
        count_nxt = CW'(MAX_SLOTS);
      end else begin
        count_nxt = CW'(cfg_data);
      end
    end
    out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  // Bitmap and summary RAMs, registered read
  always_ff @(posedge clk) begin
    if (bm_we) bm_mem[bm_waddr] <= bm_wdata;
    if (bm_re) bm_rdata_r <= bm_mem[bm_raddr];
  end

  always_ff @(posedge clk) begin
    if (sm_we) sm_mem[sm_waddr] <= sm_wdata;
    if (sm_re) sm_rdata_r <= sm_mem[sm_raddr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      count_r     <= CW'(RST_COUNT);
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    scan_r  <= scan_nxt;
    wrap_r  <= wrap_nxt;
    word_r  <= word_nxt;
    bit_r   <= bit_nxt;
    if (out_load) begin
      out_slot_r <= out_load_full ? '0 : CFA_SLOT_W'({word_r, bit_r});
      out_full_r <= out_load_full;
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = CFA_OUT_DATA_W'(out_slot_r);
  assign out_tuser  = out_full_r;

endmodule

// File: rtl/core/cfa_checker.sv
// Port-level checks of the allocator, bound to the top level.
module cfa_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic                                in_tuser,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [cfa_pkg::CFA_OUT_DATA_W-1:0]  out_tdata,
  input logic                                out_tuser,
  input logic                                cfg_valid,
  input logic                                cfg_ready
);
  import cfa_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Reset starts the rebuild sweep
  a_rst_sweep: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input ready straight after reset");

  // A count write starts the rebuild sweep
  a_cfg_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_tready)
    else $error("input ready straight after a count write");

  // An accepted allocate holds off the next request
  a_alloc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == CFA_MODE_ALLOC && !cfg_valid |=> !in_tready)
    else $error("request taken during an allocate");

  // A new result returns the block to idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) && !$past(cfg_valid) |-> in_tready)
    else $error("block not idle after issuing a result");

endmodule

bind circular_first_free_allocator cfa_checker u_cfa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);

// File: dv/tb_circular_first_free_allocator.sv
// Self-checking testbench for the circular first-free slot allocator.
module tb_circular_first_free_allocator;
  import cfa_pkg::*;

  localparam int SLOT_LIMIT    = CFA_MAX_SLOTS_DEF;
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD     = 200;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_ITEMS   = 57;

  typedef struct packed {
    logic                  full;
    logic [CFA_SLOT_W-1:0] slot;
  } grant_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic                   mode;
    logic [CFA_COUNT_W-1:0] value;  // slot for a request, spot_count for a write
    logic                   typed;
    grant_t                 want;
  } stim_row_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_tvalid;
  logic                      in_tready;
  logic [CFA_IN_DATA_W-1:0]  in_tdata;   // [9:0] slot
  logic                      in_tuser;   // [0] mode
  logic                      out_tvalid;
  logic                      out_tready;
  logic [CFA_OUT_DATA_W-1:0] out_tdata;  // [9:0] granted_slot
  logic                      out_tuser;  // [0] full_res
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFA_COUNT_W-1:0]    cfg_data;   // spot_count

  circular_first_free_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Shadow occupancy: set = slot free
  logic        slot_free [0:SLOT_LIMIT-1];
  int unsigned live_count;

  grant_t      grant_queue[$];
  stim_row_t   directed_rows[$];
  grant_t      seen;
  grant_t      want;

  int unsigned n_items;
  int unsigned n_grants;
  int unsigned n_full;
  int unsigned n_writes;
  int unsigned n_errors;
  int unsigned cycle_count;
  logic        steady;
  logic        long_hold_req;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Cycle limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: timeout after %0d cycles", cycle_count);
    $display("tb: failure");
    $finish;
  end

  // Shadow model of the allocator
  function automatic void load_count(input logic [CFA_COUNT_W-1:0] v);
    live_count = (v > SLOT_LIMIT) ? SLOT_LIMIT : v;
    for (int i = 0; i < SLOT_LIMIT; i++) begin
      slot_free[i] = (i < live_count);
    end
  endfunction

  function automatic void free_slot(input logic [CFA_SLOT_W-1:0] s);
    if (s < live_count) begin
      slot_free[s] = 1'b1;
    end
  endfunction

  // Lowest free slot at or above the preferred one, else lowest free overall
  function automatic grant_t take_first_free(input logic [CFA_SLOT_W-1:0] pref);
    grant_t g;
    int     hit;
    hit = -1;
    if (pref < live_count) begin
      for (int i = pref; i < live_count; i++) begin
        if (slot_free[i]) begin
          hit = i;
          break;
        end
      end
    end
    if (hit < 0) begin
      for (int i = 0; i < live_count; i++) begin
        if (slot_free[i]) begin
          hit = i;
          break;
        end
      end
    end
    if (hit < 0) begin
      g.full = 1'b1;
      g.slot = '0;
    end else begin
      g.full = 1'b0;
      g.slot = CFA_SLOT_W'(hit);
      slot_free[hit] = 1'b0;
    end
    return g;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("tb: cycle %0d mismatch: %s", cycle_count, msg);
    n_errors++;
  endtask

  // Offer one request; updates the shadow model on acceptance
  task automatic send_request(input logic m, input logic [CFA_SLOT_W-1:0] s,
                              input logic typed, input grant_t typed_want);
    int unsigned r;
    int unsigned gap;
    grant_t      g;
    gap = 0;
    if (!steady) begin
      r = $urandom_range(0, 99);
      if (r >= 95) gap = $urandom_range(8, 30);
      else if (r >= 70) gap = $urandom_range(1, 3);
    end
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= CFA_IN_DATA_W'(s);
    in_tuser  <= m;
    do @(posedge clk); while (!in_tready);
    n_items++;
    if (m == CFA_MODE_RELEASE) begin
      free_slot(s);
    end else begin
      g = take_first_free(s);
      grant_queue.push_back(typed ? typed_want : g);
    end
  endtask

  task automatic source_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (grant_queue.size() != 0) @(posedge clk);
  endtask

  // Register write, only once the block has gone quiet
  task automatic write_count(input logic [CFA_COUNT_W-1:0] v);
    source_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    load_count(v);
    n_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_req(input logic m, input int s, input logic typed,
                         input int exp_slot, input logic exp_full);
    stim_row_t row;
    row.kind      = ROW_REQ;
    row.mode      = m;
    row.value     = CFA_COUNT_W'(s);
    row.typed     = typed;
    row.want.slot = CFA_SLOT_W'(exp_slot);
    row.want.full = exp_full;
    directed_rows.push_back(row);
  endtask

  task automatic add_cfg(input int v);
    stim_row_t row;
    row.kind  = ROW_CFG;
    row.mode  = CFA_MODE_ALLOC;
    row.value = CFA_COUNT_W'(v);
    row.typed = 1'b0;
    row.want  = '0;
    directed_rows.push_back(row);
  endtask

  // One random request, biased towards slots that matter for the current count
  task automatic random_request(input int unsigned alloc_pct);
    logic                  m;
    logic [CFA_SLOT_W-1:0] s;
    int unsigned           pick;
    int unsigned           start;
    int                    idx;
    m    = ($urandom_range(0, 99) < alloc_pct) ? CFA_MODE_ALLOC : CFA_MODE_RELEASE;
    pick = $urandom_range(0, 99);
    s    = CFA_SLOT_W'($urandom);
    if (m == CFA_MODE_RELEASE && pick < 50 && live_count != 0) begin
      // aim at an occupied slot where there is one
      start = $urandom_range(0, live_count - 1);
      s     = CFA_SLOT_W'(start);
      for (int k = 0; k < live_count; k++) begin
        idx = (start + k) % live_count;
        if (!slot_free[idx]) begin
          s = CFA_SLOT_W'(idx);
          break;
        end
      end
    end else if (pick < 75 && live_count != 0) begin
      s = CFA_SLOT_W'($urandom_range(0, live_count - 1));
    end else if (pick >= 88) begin
      case ($urandom_range(0, 3))
        0: s = '0;
        1: s = '1;
        2: s = CFA_SLOT_W'(live_count - 1);
        default: s = CFA_SLOT_W'(live_count);
      endcase
    end
    send_request(m, s, 1'b0, '0);
  endtask

  // Receiver: random stalls, plus one long hold on request
  initial begin
    int unsigned hold_left;
    int unsigned r;
    out_tready = 1'b0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      r = $urandom_range(0, 99);
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_tready <= 1'b0;
        hold_left = LONG_HOLD - 1;
      end else if (!steady && r < 8) begin
        out_tready <= 1'b0;
        hold_left = $urandom_range(0, 2);
      end else if (!steady && r < 10) begin
        out_tready <= 1'b0;
        hold_left = $urandom_range(15, 40);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen.slot = out_tdata[CFA_SLOT_W-1:0];
      seen.full = out_tuser;
      n_grants++;
      if (seen.full) n_full++;
      if (grant_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected result slot %0d full %0b",
                                  seen.slot, seen.full));
      end else begin
        want = grant_queue.pop_front();
        if (seen.slot !== want.slot) begin
          report_mismatch($sformatf("granted_slot %0d, expected %0d", seen.slot, want.slot));
        end
        if (seen.full !== want.full) begin
          report_mismatch($sformatf("full_res %0b, expected %0b", seen.full, want.full));
        end
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned phase_count [8];
    int unsigned phase_alloc [8];
    stim_row_t   row;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = CFA_MODE_ALLOC;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    steady        = 1'b0;
    long_hold_req = 1'b0;
    n_items       = 0;
    n_grants      = 0;
    n_full        = 0;
    n_writes      = 0;
    n_errors      = 0;
    load_count(CFA_COUNT_W'(CFA_COUNT_RST));

    // Directed table: wrap, full, out-of-range and count extremes
    add_req(CFA_MODE_ALLOC,   0,    1'b1, 0,    1'b0);
    add_req(CFA_MODE_ALLOC,   1023, 1'b1, 1023, 1'b0);
    add_req(CFA_MODE_ALLOC,   1023, 1'b1, 1,    1'b0);  // wraps to lowest free
    add_req(CFA_MODE_RELEASE, 0,    1'b0, 0,    1'b0);
    add_req(CFA_MODE_RELEASE, 0,    1'b0, 0,    1'b0);  // already free
    add_req(CFA_MODE_ALLOC,   700,  1'b1, 700,  1'b0);
    add_cfg(2);
    add_req(CFA_MODE_ALLOC,   1,    1'b1, 1,    1'b0);
    add_req(CFA_MODE_ALLOC,   1,    1'b1, 0,    1'b0);
    add_req(CFA_MODE_ALLOC,   0,    1'b1, 0,    1'b1);  // no slot left
    add_req(CFA_MODE_RELEASE, 5,    1'b0, 0,    1'b0);  // beyond count, ignored
    add_req(CFA_MODE_ALLOC,   900,  1'b1, 0,    1'b1);
    add_req(CFA_MODE_RELEASE, 1,    1'b0, 0,    1'b0);
    add_req(CFA_MODE_ALLOC,   900,  1'b1, 1,    1'b0);  // preference beyond count
    add_cfg(0);
    add_req(CFA_MODE_ALLOC,   0,    1'b1, 0,    1'b1);
    add_req(CFA_MODE_RELEASE, 0,    1'b0, 0,    1'b0);
    add_req(CFA_MODE_ALLOC,   1023, 1'b1, 0,    1'b1);
    add_cfg(2047);                                       // saturates to the maximum
    add_req(CFA_MODE_ALLOC,   1023, 1'b1, 1023, 1'b0);
    add_req(CFA_MODE_ALLOC,   512,  1'b0, 0,    1'b0);
    add_cfg(1);
    add_req(CFA_MODE_ALLOC,   0,    1'b1, 0,    1'b0);
    add_req(CFA_MODE_ALLOC,   0,    1'b1, 0,    1'b1);
    add_req(CFA_MODE_RELEASE, 0,    1'b0, 0,    1'b0);
    add_req(CFA_MODE_ALLOC,   1023, 1'b1, 0,    1'b0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        write_count(row.value);
      end else begin
        send_request(row.mode, CFA_SLOT_W'(row.value), row.typed, row.want);
      end
    end

    // Random phases over a spread of counts
    phase_count = '{1024, 7, 1, 64, 0, 1500, 33, 0};
    phase_alloc = '{85, 55, 50, 70, 50, 55, 65, 55};
    phase_count[7] = $urandom_range(2, 1023);
    foreach (phase_count[p]) begin
      write_count(CFA_COUNT_W'(phase_count[p]));
      steady = ($urandom_range(0, 3) == 0);
      // first phase: receiver holds off while requests keep coming
      if (p == 0) long_hold_req = 1'b1;
      repeat (PHASE_ITEMS) random_request(phase_alloc[p]);
    end
    steady = 1'b0;

    source_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("tb: %0d requests over %0d count settings, incl. zero and saturated counts",
             n_items, n_writes);
    $display("tb: %0d results checked, %0d of them full, %0d mismatches",
             n_grants, n_full, n_errors);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
